>>> hw/rtl/pst_pkg.sv
// shared constants and types for the process slot table
package pst_pkg;

  localparam int SlotsDef  = 16;
  localparam int IdBitsDef = 16;

  localparam int ModeW   = 2;
  localparam int SlotFW  = 4;
  localparam int PidW    = 16;
  localparam int AsidW   = 8;
  localparam int PaddrW  = 2;
  localparam int PdataW  = 32;

  localparam logic [ModeW-1:0] ModeAlloc  = 2'd0;
  localparam logic [ModeW-1:0] ModeDelete = 2'd1;
  localparam logic [ModeW-1:0] ModeNext   = 2'd2;

  localparam logic [PaddrW-1:0] RegAsidBase = 2'd0;
  localparam logic [AsidW-1:0]  AsidBaseRst = 8'd1;

  typedef struct packed {
    logic alloc;
    logic inject;
    logic flush;
    logic del;
  } pst_cmd_t;

endpackage

>>> hw/rtl/pst_if.sv
// valid/ready channel interfaces for requests and results
interface pst_req_if;
  logic                         valid;
  logic                         ready;
  logic [pst_pkg::ModeW-1:0]    mode;
  logic [pst_pkg::SlotFW-1:0]   slot;

  modport source (output valid, mode, slot, input ready);
  modport sink   (input valid, mode, slot, output ready);
endinterface

interface pst_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         status;
  logic [pst_pkg::SlotFW-1:0]   found_slot;
  logic [pst_pkg::PidW-1:0]     process_id;
  logic [pst_pkg::AsidW-1:0]    address_space_id;

  modport source (output valid, status, found_slot, process_id, address_space_id,
                  input ready);
  modport sink   (input valid, status, found_slot, process_id, address_space_id,
                  output ready);
endinterface

>>> hw/rtl/process_slot_table.sv
// process slot table top level: ring of slot cells, sequencer, config register
//
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    mode, slot
//  out_o    out  valid/ready    status, found_slot, process_id, address_space_id
//  apb      in   psel/penable   asid_base at byte address 0
//
// delete and unused codes: the result goes through the done state into out_o, and ready returns as it loads
// allocate and next: the token visits 1 to SLOTS cells, then the result goes through done into out_o
// the token moves one cell per cycle around the ring, so SLOTS sets the worst case
// reset frees every slot, sets the id counter to 1 and asid_base to 1
// a waiting result in out_o does not block the next request until its own scan ends
module process_slot_table #(
  parameter int SLOTS   = pst_pkg::SlotsDef,
  parameter int ID_BITS = pst_pkg::IdBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pst_req_if.sink                      in_i,
  pst_rsp_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pst_pkg::PaddrW-1:0]   paddr,
  input  logic [pst_pkg::PdataW-1:0]   pwdata,
  output logic [pst_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [pst_pkg::AsidW-1:0]       asid_base_q;
  pst_pkg::pst_cmd_t               cmd;
  logic [SLOT_W-1:0]               inject_idx;
  logic [SLOT_W-1:0]               del_idx;
  logic [ID_BITS-1:0]              new_id;
  logic [SLOTS-1:0]                hit;
  logic [SLOTS-1:0]                tok;
  logic [SLOTS-1:0][ID_BITS-1:0]   ids;

  assign pready = 1'b1;
  assign prdata = (paddr == pst_pkg::RegAsidBase)
                  ? {{(pst_pkg::PdataW - pst_pkg::AsidW){1'b0}}, asid_base_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asid_base_q <= pst_pkg::AsidBaseRst;
    end else if (psel && penable && pwrite) begin
      asid_base_q <= pwdata[pst_pkg::AsidW-1:0];
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_cell
    pst_cell #(
      .ID_BITS (ID_BITS),
      .SLOT_W  (SLOT_W),
      .INDEX   (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .inject_idx_i (inject_idx),
      .del_idx_i    (del_idx),
      .new_id_i     (new_id),
      .tok_i        (tok[(k + SLOTS - 1) % SLOTS]),
      .tok_o        (tok[k]),
      .hit_o        (hit[k]),
      .id_o         (ids[k])
    );
  end

  pst_ctrl #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS),
    .SLOT_W  (SLOT_W)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_mode_i    (in_i.mode),
    .in_slot_i    (in_i.slot),
    .in_ready_o   (in_i.ready),
    .asid_base_i  (asid_base_q),
    .cmd_o        (cmd),
    .inject_idx_o (inject_idx),
    .del_idx_o    (del_idx),
    .new_id_o     (new_id),
    .hit_i        (hit),
    .id_i         (ids),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_status_o (out_o.status),
    .out_slot_o   (out_o.found_slot),
    .out_pid_o    (out_o.process_id),
    .out_asid_o   (out_o.address_space_id)
  );

endmodule

>>> hw/rtl/pst_cell.sv
// one slot of the table, passes the search token to its neighbor
module pst_cell #(
  parameter int ID_BITS = pst_pkg::IdBitsDef,
  parameter int SLOT_W  = 4,
  parameter int INDEX   = 0
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pst_pkg::pst_cmd_t   cmd_i,
  input  logic [SLOT_W-1:0]   inject_idx_i,
  input  logic [SLOT_W-1:0]   del_idx_i,
  input  logic [ID_BITS-1:0]  new_id_i,
  input  logic                tok_i,
  output logic                tok_o,
  output logic                hit_o,
  output logic [ID_BITS-1:0]  id_o
);

  localparam logic [SLOT_W-1:0] MyIdx = SLOT_W'(INDEX);

  logic               tok_q, tok_d;
  logic [ID_BITS-1:0] id_q, id_d;
  logic               match;

  assign match = cmd_i.alloc ? (id_q == '0) : (id_q != '0);
  assign hit_o = tok_q & match;
  assign tok_o = tok_q;
  assign id_o  = id_q;

  always_comb begin
    tok_d = (cmd_i.inject & (inject_idx_i == MyIdx)) | (tok_i & ~cmd_i.flush);
    id_d  = id_q;
    if (cmd_i.del && del_idx_i == MyIdx) begin
      id_d = '0;
    end else if (cmd_i.alloc && hit_o) begin
      id_d = new_id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= 1'b0;
      id_q  <= '0;
    end else begin
      tok_q <= tok_d;
      id_q  <= id_d;
    end
  end

endmodule

>>> hw/rtl/pst_ctrl.sv
// sequencer: launches scans, collects hits, holds the result register
module pst_ctrl #(
  parameter int SLOTS   = pst_pkg::SlotsDef,
  parameter int ID_BITS = pst_pkg::IdBitsDef,
  parameter int SLOT_W  = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic [pst_pkg::ModeW-1:0]         in_mode_i,
  input  logic [pst_pkg::SlotFW-1:0]        in_slot_i,
  output logic                              in_ready_o,
  input  logic [pst_pkg::AsidW-1:0]         asid_base_i,
  output pst_pkg::pst_cmd_t                 cmd_o,
  output logic [SLOT_W-1:0]                 inject_idx_o,
  output logic [SLOT_W-1:0]                 del_idx_o,
  output logic [ID_BITS-1:0]                new_id_o,
  input  logic [SLOTS-1:0]                  hit_i,
  input  logic [SLOTS-1:0][ID_BITS-1:0]     id_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              out_status_o,
  output logic [pst_pkg::SlotFW-1:0]        out_slot_o,
  output logic [pst_pkg::PidW-1:0]          out_pid_o,
  output logic [pst_pkg::AsidW-1:0]         out_asid_o
);

  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam logic [SLOT_W-1:0] LastIdx = SLOT_W'(SLOTS - 1);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                  state_q, state_d;
  logic [SLOT_W-1:0]           pos_q, pos_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  logic                        op_alloc_q, op_alloc_d;
  logic [ID_BITS-1:0]          cnt_q, cnt_d;
  logic                        res_status_q, res_status_d;
  logic [SLOT_W-1:0]           res_slot_q, res_slot_d;
  logic [ID_BITS-1:0]          res_id_q, res_id_d;
  logic [pst_pkg::AsidW-1:0]   res_asid_q, res_asid_d;
  logic                        out_valid_q;
  logic                        load;
  logic                        accept;
  logic                        in_range;
  logic [SLOT_W-1:0]           cur, start, in_idx;
  logic                        any_hit;
  logic [ID_BITS-1:0]          id_sel;
  logic [ID_BITS-1:0]          cnt_inc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign in_range   = ({28'd0, in_slot_i} < 32'(SLOTS));
  assign in_idx     = SLOT_W'(in_slot_i);
  assign cur        = in_range ? in_idx : LastIdx;
  assign start      = (cur == LastIdx) ? '0 : cur + 1'b1;
  assign any_hit    = |hit_i;
  assign cnt_inc    = (cnt_q == '1) ? ID_BITS'(1) : cnt_q + 1'b1;
  assign new_id_o   = cnt_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    id_sel = '0;
    for (int k = 0; k < SLOTS; k++) begin
      id_sel = id_sel | (id_i[k] & {ID_BITS{hit_i[k]}});
    end
  end

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    rem_d        = rem_q;
    op_alloc_d   = op_alloc_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_id_d     = res_id_q;
    res_asid_d   = res_asid_q;
    cmd_o        = '0;
    inject_idx_o = '0;
    del_idx_o    = in_idx;
    load         = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_status_d = 1'b1;
          res_slot_d   = '0;
          res_id_d     = '0;
          res_asid_d   = '0;
          state_d      = ST_DONE;
          case (in_mode_i)
            pst_pkg::ModeAlloc, pst_pkg::ModeNext: begin
              op_alloc_d   = (in_mode_i == pst_pkg::ModeAlloc);
              cmd_o.inject = 1'b1;
              inject_idx_o = op_alloc_d ? '0 : start;
              pos_d        = inject_idx_o;
              rem_d        = CNT_W'(SLOTS);
              state_d      = ST_SCAN;
            end
            pst_pkg::ModeDelete: begin
              if (in_range) begin
                cmd_o.del    = 1'b1;
                res_status_d = 1'b0;
                res_slot_d   = in_idx;
                res_asid_d   = asid_base_i + pst_pkg::AsidW'(in_idx);
              end
            end
            default: begin
              res_status_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.alloc = op_alloc_q;
        if (any_hit) begin
          cmd_o.flush  = 1'b1;
          res_status_d = 1'b0;
          res_slot_d   = pos_q;
          res_id_d     = op_alloc_q ? cnt_q : id_sel;
          res_asid_d   = asid_base_i + pst_pkg::AsidW'(pos_q);
          if (op_alloc_q) begin
            cnt_d = cnt_inc;
          end
          state_d = ST_DONE;
        end else if (rem_q == CNT_W'(1)) begin
          cmd_o.flush  = 1'b1;
          res_status_d = 1'b1;
          res_slot_d   = '0;
          res_id_d     = '0;
          res_asid_d   = '0;
          state_d      = ST_DONE;
        end else begin
          pos_d = (pos_q == LastIdx) ? '0 : pos_q + 1'b1;
          rem_d = rem_q - 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      rem_q       <= '0;
      op_alloc_q  <= 1'b0;
      cnt_q       <= ID_BITS'(1);
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      rem_q      <= rem_d;
      op_alloc_q <= op_alloc_d;
      cnt_q      <= cnt_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_id_q     <= res_id_d;
    res_asid_q   <= res_asid_d;
    if (load) begin
      out_status_o <= res_status_q;
      out_slot_o   <= pst_pkg::SlotFW'(res_slot_q);
      out_pid_o    <= pst_pkg::PidW'(res_id_q);
      out_asid_o   <= res_asid_q;
    end
  end

endmodule
